// ===== rtl/ledfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledfd_pkg
// Types and constants shared by the LED fade dimmer modules.
// ----------------------------------------------------------------------------
package ledfd_pkg;

  localparam int FRAME_BYTES = 10;

  localparam int STEP_W  = 10;
  localparam int LEVEL_W = 8;
  localparam int RAMP_W  = 16;
  localparam int FADE_W  = 14;
  localparam int NUM_W   = RAMP_W + LEVEL_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] CMD_FRAME  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_BUTTON = 2'd2;

  localparam logic [7:0] CODE_FADE   = 8'd1;
  localparam logic [7:0] CODE_TARGET = 8'd2;

  localparam logic [1:0] MODE_LEVEL = 2'd0;
  localparam logic [1:0] MODE_OFF   = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;

  localparam logic [7:0]         MARK_START = 8'h28;
  localparam logic [7:0]         MARK_END   = 8'h29;
  localparam logic [7:0]         FADE_LIMIT = 8'h0A;
  localparam logic [FADE_W-1:0]  FADE_UNIT  = 14'd1000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [STEP_W-1:0]  STEP_RESET = 10'd10;
  localparam logic [FADE_W-1:0]  FADE_RESET = 14'd6000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte_0;
    logic [7:0] rx_byte_1;
    logic [7:0] rx_byte_2;
    logic [7:0] rx_byte_3;
    logic [7:0] rx_byte_4;
    logic [7:0] rx_byte_5;
    logic [7:0] rx_byte_6;
    logic [7:0] rx_byte_7;
    logic [7:0] rx_byte_8;
    logic [7:0] rx_byte_9;
  } ledfd_in_t;

  typedef struct packed {
    logic       ack_send;
    logic       drive_update;
    logic [1:0] drive_mode;
    logic [7:0] level;
  } ledfd_out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FADE,
    OP_TARGET,
    OP_ACK,
    OP_TICK,
    OP_BUTTON
  } ledfd_op_t;

  typedef struct packed {
    ledfd_op_t  op;
    logic [7:0] val;
  } ledfd_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } ledfd_bstate_t;

endpackage

// ===== rtl/led_fade_dimmer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_fade_dimmer
// LED fade dimmer: frame, tick and button decode with a divided fade ramp.
// ----------------------------------------------------------------------------
// Frames, buttons and ticks at target go from the queue to the emit state;
//   a ramping tick first runs the 24-step divider. The next op is popped
//   only once the result is loaded, which waits while the output is stalled.
// reset: synchronous active low, control regs at once, no sweep
// ----------------------------------------------------------------------------
module led_fade_dimmer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ledfd_pkg::ledfd_in_t           in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ledfd_pkg::ledfd_out_t          out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ledfd_pkg::STEP_W-1:0]   cfg_data
);
  import ledfd_pkg::*;

  logic         q_full;
  logic         q_empty;
  logic         push_valid;
  ledfd_entry_t push_entry;
  logic         q_pop;
  ledfd_entry_t q_entry;

  assign cfg_ready = 1'b1;

  ledfd_front u_front (
    .in_item    (in_item),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  ledfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  ledfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/ledfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledfd_front
// Accepts input items, checks frame markers and decodes each item into an op.
// ----------------------------------------------------------------------------
module ledfd_front (
  input  ledfd_pkg::ledfd_in_t    in_item,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    q_full,
  output logic                    push_valid,
  output ledfd_pkg::ledfd_entry_t push_entry
);
  import ledfd_pkg::*;

  logic [8:0] end_pos;
  logic [7:0] end_byte;
  logic       frame_ok;

  assign end_pos = {1'b0, in_item.rx_byte_1} + 9'd2;

  always_comb begin
    case (end_pos[3:0])
      4'd2:    end_byte = in_item.rx_byte_2;
      4'd3:    end_byte = in_item.rx_byte_3;
      4'd4:    end_byte = in_item.rx_byte_4;
      4'd5:    end_byte = in_item.rx_byte_5;
      4'd6:    end_byte = in_item.rx_byte_6;
      4'd7:    end_byte = in_item.rx_byte_7;
      4'd8:    end_byte = in_item.rx_byte_8;
      4'd9:    end_byte = in_item.rx_byte_9;
      default: end_byte = 8'h00;
    endcase
  end

  assign frame_ok = (in_item.rx_byte_0 == MARK_START) &&
                    (end_pos < 9'(FRAME_BYTES)) && (end_pos <= 9'd9) &&
                    (end_byte == MARK_END);

  always_comb begin
    push_entry.val = in_item.rx_byte_3;
    push_entry.op  = OP_NONE;
    case (in_item.cmd)
      CMD_FRAME: begin
        if (frame_ok) begin
          if (in_item.rx_byte_2 == CODE_FADE) begin
            push_entry.op = (in_item.rx_byte_3 <= FADE_LIMIT) ? OP_FADE : OP_NONE;
          end else if (in_item.rx_byte_2 == CODE_TARGET) begin
            push_entry.op = OP_TARGET;
          end else begin
            push_entry.op = OP_ACK;
          end
        end
      end
      CMD_TICK:   push_entry.op = OP_TICK;
      CMD_BUTTON: push_entry.op = OP_BUTTON;
      default:    push_entry.op = OP_NONE;
    endcase
  end

  assign in_ready   = !q_full;
  assign push_valid = in_valid && !q_full;

endmodule

// ===== rtl/ledfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledfd_queue
// Short first-in first-out queue of decoded ops between front and back.
// ----------------------------------------------------------------------------
module ledfd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ledfd_pkg::ledfd_entry_t push_entry,
  input  logic                    pop,
  output ledfd_pkg::ledfd_entry_t pop_entry,
  output logic                    full,
  output logic                    empty
);
  import ledfd_pkg::*;

  ledfd_entry_t      slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/ledfd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledfd_div
// Restoring divider, one quotient bit per cycle, result saturated to a level.
// ----------------------------------------------------------------------------
module ledfd_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [ledfd_pkg::NUM_W-1:0]          num,
  input  logic [ledfd_pkg::FADE_W-1:0]         den,
  output logic                                 done,
  output logic [ledfd_pkg::LEVEL_W-1:0]        quot
);
  import ledfd_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [FADE_W-1:0] rem_r, rem_nxt;
  logic [FADE_W-1:0] den_r, den_nxt;
  logic [FADE_W:0]   rem_sh;
  logic [FADE_W:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_STEPS);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[FADE_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[FADE_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = (quo_r[NUM_W-1:LEVEL_W] != '0) ? LEVEL_MAX : quo_r[LEVEL_W-1:0];

endmodule

// ===== rtl/ledfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledfd_back
// Executes decoded ops in order: fade state, ramp counter, level, result.
// ----------------------------------------------------------------------------
module ledfd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [ledfd_pkg::STEP_W-1:0]         cfg_data,
  input  logic                                 q_empty,
  input  ledfd_pkg::ledfd_entry_t              q_entry,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ledfd_pkg::ledfd_out_t                out_item
);
  import ledfd_pkg::*;

  ledfd_bstate_t      state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [LEVEL_W-1:0] target_r, target_nxt;
  logic [LEVEL_W-1:0] current_r, current_nxt;
  logic [RAMP_W-1:0]  ramp_r, ramp_nxt;
  logic [FADE_W-1:0]  fade_r, fade_nxt;
  logic               light_r, light_nxt;
  logic               ack_r, ack_nxt;
  logic               upd_r, upd_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               out_valid_r, out_valid_nxt;
  ledfd_out_t         out_item_r, out_item_nxt;

  logic [RAMP_W:0]    ramp_up;
  logic [RAMP_W-1:0]  ramp_up_sat;
  logic [RAMP_W-1:0]  ramp_dn_sat;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic               div_done;
  logic [LEVEL_W-1:0] div_quot;
  logic               slot_free;

  assign ramp_up     = {1'b0, ramp_r} + (RAMP_W + 1)'(step_r);
  assign ramp_up_sat = ramp_up[RAMP_W] ? '1 : ramp_up[RAMP_W-1:0];
  assign ramp_dn_sat = (ramp_r > RAMP_W'(step_r)) ? ramp_r - RAMP_W'(step_r) : '0;
  assign div_num     = {ramp_nxt, {LEVEL_W{1'b0}}} - NUM_W'(ramp_nxt);
  assign slot_free   = !out_valid_r || out_ready;
  assign q_pop       = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = cfg_valid ? cfg_data : step_r;
    target_nxt    = target_r;
    current_nxt   = current_r;
    ramp_nxt      = ramp_r;
    fade_nxt      = fade_r;
    light_nxt     = light_r;
    ack_nxt       = ack_r;
    upd_nxt       = upd_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    div_start     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          ack_nxt   = 1'b0;
          upd_nxt   = 1'b0;
          mode_nxt  = MODE_LEVEL;
          state_nxt = B_EMIT;
          case (q_entry.op)
            OP_FADE:   fade_nxt = FADE_W'(FADE_UNIT * FADE_W'(q_entry.val));
            OP_TARGET: target_nxt = q_entry.val;
            OP_ACK:    ack_nxt = 1'b1;
            OP_BUTTON: begin
              light_nxt  = !light_r;
              target_nxt = light_r ? '0 : LEVEL_MAX;
            end
            OP_TICK: begin
              upd_nxt = 1'b1;
              if (target_r != current_r) begin
                if (fade_r == '0) begin
                  current_nxt = target_r;
                end else begin
                  ramp_nxt  = (target_r > current_r) ? ramp_up_sat : ramp_dn_sat;
                  div_start = 1'b1;
                  state_nxt = B_DIV;
                end
              end else begin
                mode_nxt = light_r ? MODE_FULL : MODE_OFF;
              end
            end
            default: ;
          endcase
        end
      end
      B_DIV: begin
        if (div_done) begin
          current_nxt = div_quot;
          state_nxt   = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          out_item_nxt.ack_send     = ack_r;
          out_item_nxt.drive_update = upd_r;
          out_item_nxt.drive_mode   = mode_r;
          out_item_nxt.level        = current_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= STEP_RESET;
      target_r    <= '0;
      current_r   <= '0;
      ramp_r      <= '0;
      fade_r      <= FADE_RESET;
      light_r     <= 1'b0;
      ack_r       <= 1'b0;
      upd_r       <= 1'b0;
      mode_r      <= MODE_LEVEL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      target_r    <= target_nxt;
      current_r   <= current_nxt;
      ramp_r      <= ramp_nxt;
      fade_r      <= fade_nxt;
      light_r     <= light_nxt;
      ack_r       <= ack_nxt;
      upd_r       <= upd_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  ledfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (fade_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == B_DIV)
    else $error("divider finished outside the divide state");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT && slot_free) |=> (out_valid_r && state_r == B_IDLE))
    else $error("result not loaded on emit");

  a_zero_fade: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && fade_r == '0) |=> state_r != B_DIV)
    else $error("divide started with zero fade time");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |=> $stable(target_r) || $past(state_r) == B_IDLE)
    else $error("target changed outside op dispatch");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_fade_dimmer: a directed table of frames, ticks
// and button presses, then random traffic over several step sizes, each
// output transfer compared against an in-bench model of the dimmer or a fixed table result.
// ----------------------------------------------------------------------------
module testbench;

  import ledfd_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int IN_W            = $bits(ledfd_in_t);
  localparam int ITEMS_PER_PHASE = 45;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    ledfd_in_t  item;
    logic       typed;
    ledfd_out_t res;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ledfd_in_t           in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ledfd_out_t          out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [STEP_W-1:0]   cfg_data  = '0;

  // dimmer model state
  logic [LEVEL_W-1:0]  want_target;
  logic [LEVEL_W-1:0]  want_level;
  logic [RAMP_W-1:0]   ramp_acc;
  logic [FADE_W-1:0]   fade_span;
  logic                lamp_on;
  logic [STEP_W-1:0]   step_amt;

  ledfd_out_t          due_outputs [$];
  ledfd_out_t          mon_want;
  dir_row_t            dir_tab [$];

  bit                  calm = 1'b0;
  int                  fail_count = 0;
  int                  idle_cycles = 0;
  int                  n_ticks = 0;
  int                  n_frames = 0;
  int                  n_presses = 0;
  int                  n_unused = 0;
  int                  n_acks = 0;

  led_fade_dimmer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // bit offset of frame byte k within the packed item
  function automatic int bpos(input int k);
    return 8 * (FRAME_BYTES - 1 - k);
  endfunction

  function automatic ledfd_out_t dimmer_next(input ledfd_in_t it);
    ledfd_out_t       r;
    int               endpos;
    logic [RAMP_W:0]  sum;
    logic [NUM_W-1:0] quo;
    r = '0;
    endpos = int'(it.rx_byte_1) + 2;
    case (it.cmd)
      CMD_FRAME: begin
        if (it.rx_byte_0 == MARK_START && endpos < FRAME_BYTES) begin
          if (it[bpos(endpos) +: 8] == MARK_END) begin
            if (it.rx_byte_2 == CODE_FADE) begin
              if (it.rx_byte_3 <= FADE_LIMIT) fade_span = FADE_UNIT * it.rx_byte_3;
            end else if (it.rx_byte_2 == CODE_TARGET) begin
              want_target = it.rx_byte_3;
            end else begin
              r.ack_send = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        r.drive_update = 1'b1;
        if (want_target == want_level) begin
          r.drive_mode = lamp_on ? MODE_FULL : MODE_OFF;
        end else begin
          r.drive_mode = MODE_LEVEL;
          if (fade_span == '0) begin
            want_level = want_target;
          end else begin
            if (want_target > want_level) begin
              sum = ramp_acc + step_amt;
              ramp_acc = sum[RAMP_W] ? '1 : sum[RAMP_W-1:0];
            end else begin
              ramp_acc = (ramp_acc > step_amt) ? ramp_acc - step_amt : '0;
            end
            quo = (ramp_acc * LEVEL_MAX) / fade_span;
            want_level = (quo > LEVEL_MAX) ? LEVEL_MAX : quo[LEVEL_W-1:0];
          end
        end
      end
      CMD_BUTTON: begin
        lamp_on = !lamp_on;
        want_target = lamp_on ? LEVEL_MAX : '0;
      end
      default: begin
      end
    endcase
    r.level = want_level;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic ledfd_in_t op_item(input logic [1:0] cmd);
    ledfd_in_t it;
    it = '0;
    it.cmd = cmd;
    return it;
  endfunction

  function automatic ledfd_in_t mk_frame(input logic [7:0] b0, len, code, val, endb, fill);
    ledfd_in_t it;
    int        endpos;
    it = '0;
    for (int k = 0; k < FRAME_BYTES; k++) it[bpos(k) +: 8] = fill;
    it.cmd = CMD_FRAME;
    it.rx_byte_0 = b0;
    it.rx_byte_1 = len;
    it.rx_byte_2 = code;
    it.rx_byte_3 = val;
    endpos = int'(len) + 2;
    if (endpos < FRAME_BYTES) it[bpos(endpos) +: 8] = endb;
    return it;
  endfunction

  function automatic ledfd_out_t drive_res(input logic ack, upd, input logic [1:0] mode,
                                           input logic [7:0] lv);
    return ledfd_out_t'{ack, upd, mode, lv};
  endfunction

  // ticks, button presses and mostly well-formed frames, some broken frames and noise
  function automatic ledfd_in_t rand_item(output bit acted);
    ledfd_in_t it;
    int        pick;
    int        len;
    it = ledfd_in_t'(IN_W'({$urandom, $urandom, $urandom}));
    acted = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.cmd = CMD_TICK;
    end else if (pick < 53) begin
      it.cmd = CMD_BUTTON;
    end else if (pick < 97) begin
      it.cmd = CMD_FRAME;
      len = $urandom_range(0, FRAME_BYTES - 3);
      it.rx_byte_0 = MARK_START;
      it.rx_byte_1 = 8'(len);
      case ($urandom_range(0, 4))
        0, 1: begin
          it.rx_byte_2 = CODE_FADE;
          if ($urandom_range(0, 4) != 0) it.rx_byte_3 = 8'($urandom_range(0, FADE_LIMIT));
        end
        2, 3: begin
          it.rx_byte_2 = CODE_TARGET;
        end
        default: begin
        end
      endcase
      it[bpos(len + 2) +: 8] = MARK_END;
      if (pick >= 82) begin
        acted = 1'b0;
        case ($urandom_range(0, 2))
          0: it.rx_byte_0 ^= 8'(1 << $urandom_range(0, 7));
          1: it[bpos(len + 2) +: 8] ^= 8'(1 << $urandom_range(0, 7));
          default: it.rx_byte_1 = 8'($urandom_range(FRAME_BYTES - 2, 255));
        endcase
      end
    end else begin
      it.cmd = CMD_UNUSED;
      acted = 1'b0;
    end
    return it;
  endfunction

  task automatic put(input ledfd_in_t it, input logic typed, input ledfd_out_t res);
    dir_tab.push_back(dir_row_t'{it, typed, res});
  endtask

  task automatic send_item(input ledfd_in_t it, input logic typed, input ledfd_out_t fixed);
    ledfd_out_t pred;
    int         gap;
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = dimmer_next(it);
    due_outputs.push_back(typed ? fixed : pred);
    case (it.cmd)
      CMD_TICK: n_ticks++;
      CMD_FRAME: n_frames++;
      CMD_BUTTON: n_presses++;
      default: n_unused++;
    endcase
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_step(input logic [STEP_W-1:0] value);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    step_amt = value;
  endtask

  // result side: random stalls, with calm stretches
  initial begin
    int hold;
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      hold = calm ? 64 : $urandom_range(1, 16);
      repeat (hold) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (out_item.ack_send) n_acks++;
      if (due_outputs.size() == 0) begin
        $error("output transfer with nothing pending: %h", out_item);
        fail_count++;
      end else begin
        mon_want = due_outputs.pop_front();
        if (out_item.ack_send !== mon_want.ack_send) begin
          $error("ack_send: expected %0d, got %0d", mon_want.ack_send, out_item.ack_send);
          fail_count++;
        end
        if (out_item.drive_update !== mon_want.drive_update) begin
          $error("drive_update: expected %0d, got %0d", mon_want.drive_update,
                 out_item.drive_update);
          fail_count++;
        end
        if (out_item.drive_mode !== mon_want.drive_mode) begin
          $error("drive_mode: expected %0d, got %0d", mon_want.drive_mode,
                 out_item.drive_mode);
          fail_count++;
        end
        if (out_item.level !== mon_want.level) begin
          $error("level: expected %0d, got %0d", mon_want.level, out_item.level);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int                acted_cnt;
    bit                acted;
    ledfd_in_t         it;
    logic [STEP_W-1:0] step_plan [7];

    want_target = '0;
    want_level  = '0;
    ramp_acc    = '0;
    fade_span   = FADE_RESET;
    lamp_on     = 1'b0;
    step_amt    = STEP_RESET;

    // tick at target after reset, unused code, first press
    put(op_item(CMD_TICK), 1'b1, drive_res(1'b0, 1'b1, MODE_OFF, 8'd0));
    put(ledfd_in_t'('1), 1'b1, '0);
    put(op_item(CMD_BUTTON), 1'b1, '0);
    // bad start, end marker out of frame, wrong end marker
    put(mk_frame(8'h00, 8'd2, 8'h05, 8'h00, MARK_END, 8'h00), 1'b1, '0);
    put(mk_frame(MARK_START, 8'd8, 8'h05, 8'h00, MARK_END, MARK_END), 1'b1, '0);
    put(mk_frame(MARK_START, 8'hFF, 8'h05, 8'h00, MARK_END, MARK_END), 1'b1, '0);
    put(mk_frame(MARK_START, 8'd2, 8'h05, 8'h00, MARK_START, 8'h00), 1'b1, '0);
    // other codes ask for the acknowledge, end marker at byte 4 and at the last byte
    put(mk_frame(MARK_START, 8'd2, 8'h05, 8'h00, MARK_END, 8'h00), 1'b1,
        drive_res(1'b1, 1'b0, MODE_LEVEL, 8'd0));
    put(mk_frame(MARK_START, 8'd7, 8'hFF, 8'hFF, MARK_END, 8'hFF), 1'b1,
        drive_res(1'b1, 1'b0, MODE_LEVEL, 8'd0));
    put(op_item(CMD_TICK), 1'b0, '0);
    // fade value above ten, then one, ten and zero seconds
    put(mk_frame(MARK_START, 8'd2, CODE_FADE, 8'd11, MARK_END, 8'h00), 1'b0, '0);
    put(mk_frame(MARK_START, 8'd3, CODE_FADE, 8'd1, MARK_END, 8'h55), 1'b0, '0);
    put(op_item(CMD_TICK), 1'b0, '0);
    put(mk_frame(MARK_START, 8'd7, CODE_FADE, FADE_LIMIT, MARK_END, 8'hAA), 1'b0, '0);
    put(op_item(CMD_TICK), 1'b0, '0);
    put(mk_frame(MARK_START, 8'd2, CODE_FADE, 8'd0, MARK_END, 8'h00), 1'b0, '0);
    put(op_item(CMD_TICK), 1'b1, drive_res(1'b0, 1'b1, MODE_LEVEL, LEVEL_MAX));
    put(op_item(CMD_TICK), 1'b1, drive_res(1'b0, 1'b1, MODE_FULL, LEVEL_MAX));
    // ramp down to zero with a one second fade
    put(mk_frame(MARK_START, 8'd2, CODE_TARGET, 8'd0, MARK_END, 8'h00), 1'b0, '0);
    put(mk_frame(MARK_START, 8'd2, CODE_FADE, 8'd1, MARK_END, 8'h00), 1'b0, '0);
    repeat (4) put(op_item(CMD_TICK), 1'b0, '0);
    put(op_item(CMD_BUTTON), 1'b0, '0);
    put(op_item(CMD_TICK), 1'b1, drive_res(1'b0, 1'b1, MODE_OFF, 8'd0));
    put(mk_frame(MARK_START, 8'd4, CODE_TARGET, LEVEL_MAX, MARK_END, 8'h00), 1'b0, '0);
    put(op_item(CMD_TICK), 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

    step_plan = '{10'd1023, 10'd0, 10'd1, 10'd1000, STEP_RESET,
                  10'($urandom_range(2, 999)), 10'($urandom_range(2, 999))};
    foreach (step_plan[p]) begin
      write_step(step_plan[p]);
      calm = ($urandom_range(0, 3) == 0);
      acted_cnt = 0;
      while (acted_cnt < ITEMS_PER_PHASE) begin
        it = rand_item(acted);
        send_item(it, 1'b0, '0);
        if (acted) acted_cnt++;
      end
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d ticks, %0d frames, %0d button presses, %0d unused commands",
             n_ticks, n_frames, n_presses, n_unused);
    $display("%0d acknowledges seen, step size swept from 0 to 1023 over %0d settings",
             n_acks, $size(step_plan) + 1);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
